### rtl/utf8_non_ascii_neutralizer_assert.svh
// -----------------------------------------------------------------------------
// utf8 neutralizer assertion macros
// shared concurrent assertion forms, all reset-qualified
// -----------------------------------------------------------------------------
`ifndef UTF8_NON_ASCII_NEUTRALIZER_ASSERT_SVH
`define UTF8_NON_ASCII_NEUTRALIZER_ASSERT_SVH

// same-cycle implication
`define UTF8N_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8n: same-cycle check failed");

// next-cycle implication
`define UTF8N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8n: next-cycle check failed");

`endif

### rtl/utf8n_pkg.sv
// -----------------------------------------------------------------------------
// utf8n_pkg
// shared types and constants of the utf8 neutralizer
// -----------------------------------------------------------------------------
package utf8n_pkg;

   localparam logic [7:0] CharU   = 8'h75;
   localparam logic [7:0] CharErr = 8'h00;

   // one result beat
   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
      logic       out_error;
   } rsp_beat_type;

   // results handed from the decoder to the output buffer at once
   typedef struct packed {
      logic [1:0]   count;
      rsp_beat_type first;
      rsp_beat_type second;
   } push_type;

   // output buffer free slots seen by the decoder
   typedef struct packed {
      logic [1:0] free;
   } buf_status_type;

endpackage

### rtl/utf8n_req_if.sv
// -----------------------------------------------------------------------------
// utf8n_req_if
// byte stream channel: valid/ready with one raw byte and a last flag
// -----------------------------------------------------------------------------
interface utf8n_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/utf8n_rsp_if.sv
// -----------------------------------------------------------------------------
// utf8n_rsp_if
// result channel: valid/ready with output byte, last and error flags
// -----------------------------------------------------------------------------
interface utf8n_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   logic       out_error;

   modport source (output valid, output out_char, output out_last, output out_error,
                   input ready);
   modport sink   (input valid, input out_char, input out_last, input out_error,
                   output ready);
endinterface

### rtl/utf8_non_ascii_neutralizer.sv
// path: input register, then result buffer; a full buffer stalls the input register
// throughput: one byte per cycle given buffer room, one beat out per cycle given ready
// a code point above the bmp yields two beats and waits for an empty two-entry buffer
// reset: synchronous, active high; clears decode state, input valid and buffer pointers
// -----------------------------------------------------------------------------
// utf8_non_ascii_neutralizer
// passes ascii, puts 'u' per utf16 unit of a multi-byte utf8 sequence, flags bad input
// -----------------------------------------------------------------------------
module utf8_non_ascii_neutralizer (
   input  logic         clock,
   input  logic         reset,
   utf8n_req_if.sink    req_bus,
   utf8n_rsp_if.source  rsp_bus
);
   import utf8n_pkg::*;

   // decoder to buffer: beats produced by the byte in the input register
   push_type       push;
   // buffer to decoder: free slots, gates the decoder so no beat is lost
   buf_status_type status;

   // input register, lead/continuation state, code point accumulator
   utf8n_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .status  (status),
      .push    (push)
   );

   // result register pair, parts the two handshakes
   utf8n_out_buf u_out_buf (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .status  (status),
      .rsp_bus (rsp_bus)
   );

endmodule

### rtl/utf8n_decode.sv
// -----------------------------------------------------------------------------
// utf8n_decode
// input register, sequence state and single-pass decode of one byte
// -----------------------------------------------------------------------------
`include "utf8_non_ascii_neutralizer_assert.svh"

module utf8n_decode (
   input  logic                     clock,
   input  logic                     reset,
   utf8n_req_if.sink                req_bus,
   input  utf8n_pkg::buf_status_type status,
   output utf8n_pkg::push_type      push
);
   import utf8n_pkg::*;

   logic         vld_ff, vld_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;
   logic [1:0]   exp_ff, exp_in;
   logic [20:0]  acc_ff, acc_in;

   logic [1:0]   n_res;
   rsp_beat_type res0, res1;
   logic [1:0]   exp_nxt;
   logic [20:0]  acc_nxt;
   logic [20:0]  acc_shift;
   logic [1:0]   exp_dec;
   logic         consume;
   logic         take;

   always_comb begin
      n_res     = 2'd0;
      res0      = '0;
      res1      = '0;
      exp_nxt   = exp_ff;
      acc_nxt   = acc_ff;
      acc_shift = {acc_ff[14:0], byte_ff[5:0]};
      exp_dec   = exp_ff - 2'd1;
      if (exp_ff == 2'd0) begin
         if (!byte_ff[7]) begin
            // plain ascii
            n_res = 2'd1;
            res0  = '{out_char: byte_ff, out_last: last_ff, out_error: 1'b0};
         end else if (byte_ff[7:3] == 5'b11111) begin
            n_res = 2'd1;
            res0  = '{out_char: CharErr, out_last: last_ff, out_error: 1'b1};
         end else if (byte_ff[7:6] == 2'b10) begin
            // stray continuation as a lead
            n_res = 2'd1;
            res0  = '{out_char: CharU, out_last: last_ff, out_error: 1'b0};
         end else if (last_ff) begin
            n_res = 2'd1;
            res0  = '{out_char: CharErr, out_last: 1'b1, out_error: 1'b1};
         end else if (byte_ff[5] == 1'b0) begin
            exp_nxt = 2'd1;
            acc_nxt = {16'd0, byte_ff[4:0]};
         end else if (byte_ff[4] == 1'b0) begin
            exp_nxt = 2'd2;
            acc_nxt = {17'd0, byte_ff[3:0]};
         end else begin
            exp_nxt = 2'd3;
            acc_nxt = {18'd0, byte_ff[2:0]};
         end
      end else if (byte_ff[7:6] != 2'b10) begin
         n_res   = 2'd1;
         res0    = '{out_char: CharErr, out_last: last_ff, out_error: 1'b1};
         exp_nxt = 2'd0;
         acc_nxt = '0;
      end else if (exp_dec == 2'd0) begin
         // sequence complete: beyond the bmp it takes a surrogate pair
         exp_nxt = 2'd0;
         acc_nxt = '0;
         if (acc_shift[20:16] != 5'd0) begin
            n_res = 2'd2;
            res0  = '{out_char: CharU, out_last: 1'b0, out_error: 1'b0};
            res1  = '{out_char: CharU, out_last: last_ff, out_error: 1'b0};
         end else begin
            n_res = 2'd1;
            res0  = '{out_char: CharU, out_last: last_ff, out_error: 1'b0};
         end
      end else if (last_ff) begin
         n_res   = 2'd1;
         res0    = '{out_char: CharErr, out_last: 1'b1, out_error: 1'b1};
         exp_nxt = 2'd0;
         acc_nxt = '0;
      end else begin
         exp_nxt = exp_dec;
         acc_nxt = acc_shift;
      end
   end

   assign consume = vld_ff && (n_res <= status.free);
   assign req_bus.ready = !vld_ff || consume;
   assign take = req_bus.valid && req_bus.ready;

   assign push.count  = consume ? n_res : 2'd0;
   assign push.first  = res0;
   assign push.second = res1;

   always_comb begin
      vld_in  = take ? 1'b1 : (consume ? 1'b0 : vld_ff);
      byte_in = take ? req_bus.in_byte : byte_ff;
      last_in = take ? req_bus.in_last : last_ff;
      exp_in  = consume ? exp_nxt : exp_ff;
      acc_in  = consume ? acc_nxt : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         exp_ff <= 2'd0;
         acc_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         exp_ff <= exp_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   `UTF8N_ASSERT_SAME(a_pair_only_on_final, clock, reset,
      push.count == 2'd2, exp_ff == 2'd1 && status.free == 2'd2)
   `UTF8N_ASSERT_SAME(a_ascii_one_beat, clock, reset,
      consume && exp_ff == 2'd0 && !byte_ff[7], push.count == 2'd1)
   `UTF8N_ASSERT_NEXT(a_silent_means_pending, clock, reset,
      consume && push.count == 2'd0, exp_ff != 2'd0)

endmodule

### rtl/utf8n_out_buf.sv
// -----------------------------------------------------------------------------
// utf8n_out_buf
// two-entry result buffer, takes up to two beats per cycle
// -----------------------------------------------------------------------------
`include "utf8_non_ascii_neutralizer_assert.svh"

module utf8n_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  utf8n_pkg::push_type       push,
   output utf8n_pkg::buf_status_type status,
   utf8n_rsp_if.source               rsp_bus
);
   import utf8n_pkg::*;

   rsp_beat_type entry_ff [2];
   rsp_beat_type entry_in [2];
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign status.free = 2'd2 - cnt_ff;

   assign rsp_bus.valid     = cnt_ff != 2'd0;
   assign rsp_bus.out_char  = entry_ff[rd_ptr_ff].out_char;
   assign rsp_bus.out_last  = entry_ff[rd_ptr_ff].out_last;
   assign rsp_bus.out_error = entry_ff[rd_ptr_ff].out_error;
   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      entry_in = entry_ff;
      if (push.count != 2'd0) begin
         entry_in[wr_ptr_ff] = push.first;
      end
      if (push.count == 2'd2) begin
         entry_in[~wr_ptr_ff] = push.second;
      end
      wr_ptr_in = wr_ptr_ff ^ push.count[0];
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + push.count - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   `UTF8N_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `UTF8N_ASSERT_SAME(a_push_fits, clock, reset, 1'b1, push.count <= status.free)
   `UTF8N_ASSERT_NEXT(a_pair_fills, clock, reset,
      push.count == 2'd2 && !pop, cnt_ff == 2'd2 && rd_ptr_ff == wr_ptr_ff)

endmodule
